### design/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;
    localparam int GRID_SIDE_DEF = 64;
    localparam int IDX_W = 8;
    localparam int H_W = 16;
    localparam int CNT_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W = 16;

    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_SWEEP = 2'd3;

    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_CLEAR = 4'd1;
    localparam logic [3:0] OP_FILL  = 4'd2;
    localparam logic [3:0] OP_WRITE = 4'd3;
    localparam logic [3:0] OP_READ  = 4'd4;
    localparam logic [3:0] OP_SCAN  = 4'd5;
    localparam logic [3:0] OP_FLRD  = 4'd6;
    localparam logic [3:0] OP_UPD   = 4'd7;
    localparam logic [3:0] OP_DROP  = 4'd8;
    localparam logic [3:0] OP_INIT  = 4'd9;

    localparam logic [1:0] FL_PREV  = 2'd0;
    localparam logic [1:0] FL_CUR   = 2'd1;
    localparam logic [1:0] FL_NEXT  = 2'd2;
    localparam logic [1:0] FL_SHIFT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DCOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP = 3'd4;

    typedef struct packed {
        logic [3:0]       op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [1:0]       fl_tgt;
        logic             fl_gate;
    } t_dp_cmd;
endpackage

### design/sps_in_if.sv
`timescale 1ns / 1ps
interface sps_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [5:0]               row;
    logic [5:0]               col;
    logic [sps_pkg::H_W-1:0]  value;
    modport source (output valid, mode, row, col, value, input ready);
    modport sink (input valid, mode, row, col, value, output ready);
endinterface

### design/sps_out_if.sv
`timescale 1ns / 1ps
interface sps_out_if;
    logic                      valid;
    logic                      ready;
    logic [sps_pkg::H_W-1:0]   cell_value;
    logic [sps_pkg::CNT_W-1:0] topple_count;
    logic                      clipped;
    modport source (output valid, cell_value, topple_count, clipped, input ready);
    modport sink (input valid, cell_value, topple_count, clipped, output ready);
endinterface

### design/sps_ctrl.sv
`timescale 1ns / 1ps
module sps_ctrl #(
    parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_mode,
    input  logic [5:0]       i_in_row,
    input  logic [5:0]       i_in_col,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output sps_pkg::t_dp_cmd o_cmd
);
    import sps_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_WR    = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_SWAIT = 4'd6;
    localparam logic [3:0] S_FLP   = 4'd7;
    localparam logic [3:0] S_FLC   = 4'd8;
    localparam logic [3:0] S_FLN   = 4'd9;
    localparam logic [3:0] S_UPD   = 4'd10;
    localparam logic [3:0] S_FLS   = 4'd11;
    localparam logic [3:0] S_GAP   = 4'd12;
    localparam logic [3:0] S_DROP  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(GRID_SIDE - 1);

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic             w_last_col, w_last_row;

    assign w_last_col = (r_col == LAST);
    assign w_last_row = (r_row == LAST);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.row   = r_row;
        o_cmd.col   = r_col;
        case (r_state)
            S_CLR, S_FILL, S_SCAN: begin
                case (r_state)
                    S_CLR:   o_cmd.op = OP_CLEAR;
                    S_FILL:  o_cmd.op = OP_FILL;
                    default: o_cmd.op = OP_SCAN;
                endcase
                if (w_last_col) begin
                    n_col = '0;
                    if (w_last_row) begin
                        n_row = '0;
                        case (r_state)
                            S_CLR:   n_state = S_IDLE;
                            S_FILL:  n_state = S_DONE;
                            default: n_state = S_SWAIT;
                        endcase
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_INIT;
                    n_row = {2'b00, i_in_row};
                    n_col = {2'b00, i_in_col};
                    case (i_in_mode)
                        MODE_FILL: begin
                            n_row = '0;
                            n_col = '0;
                            n_state = S_FILL;
                        end
                        MODE_WRITE: n_state = S_WR;
                        MODE_READ:  n_state = S_RD;
                        default: begin
                            n_row = '0;
                            n_col = '0;
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_WR: begin
                o_cmd.op = OP_WRITE;
                n_state = S_DONE;
            end
            S_RD: begin
                o_cmd.op = OP_READ;
                n_state = S_FIN;
            end
            S_SWAIT: n_state = S_FLP;
            S_FLP: begin
                o_cmd.op      = OP_FLRD;
                o_cmd.row     = LAST;
                o_cmd.fl_tgt  = FL_PREV;
                o_cmd.fl_gate = 1'b1;
                n_state = S_FLC;
            end
            S_FLC: begin
                o_cmd.op     = OP_FLRD;
                o_cmd.row    = '0;
                o_cmd.fl_tgt = FL_CUR;
                n_state = S_FLN;
            end
            S_FLN: begin
                o_cmd.op     = OP_FLRD;
                o_cmd.row    = IDX_W'(1);
                o_cmd.fl_tgt = FL_NEXT;
                n_row = '0;
                n_col = '0;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                if (w_last_col) begin
                    n_col = '0;
                    if (w_last_row) begin
                        n_state = S_GAP;
                    end else begin
                        n_row = r_row + 1'b1;
                        n_state = S_FLS;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_FLS: begin
                // Fetch the flags of the row below the one about to be updated.
                o_cmd.op     = OP_FLRD;
                o_cmd.fl_tgt = FL_SHIFT;
                if (w_last_row) begin
                    o_cmd.row     = '0;
                    o_cmd.fl_gate = 1'b1;
                end else begin
                    o_cmd.row = r_row + 1'b1;
                end
                n_state = S_UPD;
            end
            S_GAP: n_state = S_DROP;
            S_DROP: begin
                o_cmd.op = OP_DROP;
                n_state = S_FIN;
            end
            S_FIN: n_state = S_DONE;
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end
endmodule

### design/sps_dp.sv
`timescale 1ns / 1ps
module sps_dp #(
    parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sps_pkg::t_dp_cmd              i_cmd,
    input  logic [sps_pkg::H_W-1:0]       i_value,
    input  logic                          i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sps_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [sps_pkg::H_W-1:0]       o_cell_value,
    output logic [sps_pkg::CNT_W-1:0]     o_topple_count,
    output logic                          o_clipped
);
    import sps_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(GRID_SIDE);
    localparam logic [IDX_W:0] SIDE = (IDX_W + 1)'(GRID_SIDE);
    localparam logic [CW-1:0] CLAST = CW'(GRID_SIDE - 1);

    logic [H_W-1:0]       r_mem [CELLS];
    logic [GRID_SIDE-1:0] r_fmem [GRID_SIDE];

    logic [H_W-1:0]   r_fill, r_value;
    logic [5:0]       r_drow, r_dcol;
    logic [7:0]       r_damt;
    logic             r_wrap;
    logic [H_W-1:0]   r_rdata;
    logic [GRID_SIDE-1:0] r_fdata, r_frow, r_fprev, r_fcur, r_fnext;
    t_dp_cmd          r_cmd_d;
    logic [AW-1:0]    r_addr_d;
    logic             r_inr_d;
    logic [H_W-1:0]   r_cell_value;
    logic [CNT_W-1:0] r_topples;
    logic             r_clipped;

    logic [AW-1:0]    w_addr0, w_daddr, w_raddr, w_waddr;
    logic             w_inr, w_dinr, w_re, w_we;
    logic [H_W-1:0]   w_wdata;
    logic [CW-1:0]    w_c, w_cl, w_cr;
    logic             w_self, w_top, w_bot, w_left, w_right, w_hot;
    logic [H_W:0]     w_usum, w_dsum;
    logic [GRID_SIDE-1:0] w_frow_set, w_fload;

    assign w_addr0 = AW'(32'(i_cmd.row) * GRID_SIDE + 32'(i_cmd.col));
    assign w_daddr = AW'(32'(r_drow) * GRID_SIDE + 32'(r_dcol));
    assign w_inr   = ({1'b0, i_cmd.row} < SIDE) && ({1'b0, i_cmd.col} < SIDE);
    assign w_dinr  = ({3'b000, r_drow} < SIDE) && ({3'b000, r_dcol} < SIDE);
    assign w_raddr = (i_cmd.op == OP_DROP) ? w_daddr : w_addr0;
    assign w_re    = (i_cmd.op == OP_READ) || (i_cmd.op == OP_SCAN)
                  || (i_cmd.op == OP_UPD) || (i_cmd.op == OP_DROP);

    // Neighbor flags of the cell in the second stage, judged on the old grid.
    assign w_c     = r_cmd_d.col[CW-1:0];
    assign w_cl    = (w_c == '0) ? CLAST : w_c - 1'b1;
    assign w_cr    = (w_c == CLAST) ? '0 : w_c + 1'b1;
    assign w_self  = r_fcur[w_c];
    assign w_top   = r_fprev[w_c];
    assign w_bot   = r_fnext[w_c];
    assign w_left  = r_fcur[w_cl] & ((w_c != '0) | r_wrap);
    assign w_right = r_fcur[w_cr] & ((w_c != CLAST) | r_wrap);
    assign w_hot   = (r_rdata > H_W'(3));
    assign w_usum  = (H_W + 1)'(r_rdata) - (w_self ? (H_W + 1)'(4) : '0)
                   + (H_W + 1)'(w_top) + (H_W + 1)'(w_bot)
                   + (H_W + 1)'(w_left) + (H_W + 1)'(w_right);
    assign w_dsum  = (H_W + 1)'(r_rdata) + (H_W + 1)'(r_damt);
    assign w_fload = (r_cmd_d.fl_gate && !r_wrap) ? '0 : r_fdata;

    always_comb begin
        w_frow_set = r_frow;
        w_frow_set[w_c] = w_hot;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr0;
        w_wdata = '0;
        if (r_cmd_d.op == OP_UPD) begin
            w_we    = 1'b1;
            w_waddr = r_addr_d;
            w_wdata = w_usum[H_W] ? '1 : w_usum[H_W-1:0];
        end else if (r_cmd_d.op == OP_DROP) begin
            w_we    = r_inr_d;
            w_waddr = r_addr_d;
            w_wdata = w_dsum[H_W] ? '1 : w_dsum[H_W-1:0];
        end else begin
            case (i_cmd.op)
                OP_CLEAR: w_we = 1'b1;
                OP_FILL: begin
                    w_we    = 1'b1;
                    w_wdata = r_fill;
                end
                OP_WRITE: begin
                    w_we    = w_inr;
                    w_wdata = r_value;
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
        if (i_cmd.op == OP_FLRD) begin
            r_fdata <= r_fmem[i_cmd.row[CW-1:0]];
        end
        if (r_cmd_d.op == OP_SCAN && w_c == CLAST) begin
            r_fmem[r_cmd_d.row[CW-1:0]] <= w_frow_set;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_d <= (i_cmd.op == OP_DROP) ? w_daddr : w_addr0;
        r_inr_d  <= (i_cmd.op == OP_DROP) ? w_dinr : w_inr;
        if (i_cmd.op == OP_INIT) begin
            r_value      <= i_value;
            r_cell_value <= '0;
            r_topples    <= '0;
            r_clipped    <= 1'b0;
        end
        case (r_cmd_d.op)
            OP_READ: r_cell_value <= r_inr_d ? r_rdata : '0;
            OP_SCAN: begin
                r_frow <= w_frow_set;
                if (w_hot && r_topples != '1) begin
                    r_topples <= r_topples + 1'b1;
                end
            end
            OP_UPD: begin
                if (w_usum[H_W]) begin
                    r_clipped <= 1'b1;
                end
            end
            OP_DROP: begin
                if (r_inr_d && w_dsum[H_W]) begin
                    r_clipped <= 1'b1;
                end
            end
            OP_FLRD: begin
                case (r_cmd_d.fl_tgt)
                    FL_PREV: r_fprev <= w_fload;
                    FL_CUR:  r_fcur  <= w_fload;
                    FL_NEXT: r_fnext <= w_fload;
                    default: begin
                        r_fprev <= r_fcur;
                        r_fcur  <= r_fnext;
                        r_fnext <= w_fload;
                    end
                endcase
            end
            default: r_frow <= r_frow;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_d <= '0;
            r_fill  <= H_W'(7);
            r_drow  <= 6'd32;
            r_dcol  <= 6'd32;
            r_damt  <= 8'd3;
            r_wrap  <= 1'b0;
        end else begin
            r_cmd_d <= i_cmd;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL: r_fill <= i_cfg_data;
                    CFG_DROW: r_drow <= i_cfg_data[5:0];
                    CFG_DCOL: r_dcol <= i_cfg_data[5:0];
                    CFG_DAMT: r_damt <= i_cfg_data[7:0];
                    CFG_WRAP: r_wrap <= i_cfg_data[0];
                    default:  r_wrap <= r_wrap;
                endcase
            end
        end
    end

    assign o_cell_value   = r_cell_value;
    assign o_topple_count = r_topples;
    assign o_clipped      = r_clipped;
endmodule

### design/sandpile_toppling_step_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                              Handshake
// i_in      in   mode, row, col, value                valid / ready
// o_out     out  cell_value, topple_count, clipped    valid / ready
// i_cfg_*   in   register index and data              write enable, no wait
//
// A sweep with drop makes two passes: one pass over the height memory records the
// toppling flags row by row, a second pass updates every cell from them.
// After reset a clearing pass zeroes the grid; no word is taken until it ends. One
// word is worked on at a time; the result word holds until it is taken, and the next
// word is accepted after that.
module sandpile_toppling_step_unit #(
    parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sps_in_if.sink                        i_in,
    sps_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sps_pkg::CFG_W-1:0]     i_cfg_data
);
    import sps_pkg::*;

    t_dp_cmd w_cmd;

    // The controller sequences cell visits; the datapath owns the memories.
    sps_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .i_in_row    (i_in.row),
        .i_in_col    (i_in.col),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    sps_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_in.value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_cell_value   (o_out.cell_value),
        .o_topple_count (o_out.topple_count),
        .o_clipped      (o_out.clipped)
    );

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready stayed high after a word was taken");
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.cell_value != '0)
        |-> (o_out.topple_count == '0 && !o_out.clipped))
        else $error("read result carries sweep status");
`endif
endmodule

### dv/sandpile_sweep_checker.sv
`timescale 1ns / 1ps
module sandpile_sweep_checker
    import sps_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sps_in_if                    in_ch,
    sps_out_if                   out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    typedef struct packed {
        logic [H_W-1:0]   cell_value;
        logic [CNT_W-1:0] topple_count;
        logic             clipped;
    } sweep_result_t;

    logic [H_W-1:0] height_grid [CELLS];
    logic [H_W-1:0] prior_grid [CELLS];
    logic [15:0]    fill_value;
    logic [5:0]     drop_row;
    logic [5:0]     drop_col;
    logic [7:0]     drop_amount;
    logic           wrap_edges;
    sweep_result_t  expected_words [$];

    // Returns 1 when the cell at (r + dr, c + dc) held more than three grains before the sweep.
    function automatic int neighbour_grain(int r, int c, int dr, int dc);
        int nr;
        int nc;
        nr = r + dr;
        nc = c + dc;
        if (nr < 0 || nr >= GRID_SIDE || nc < 0 || nc >= GRID_SIDE) begin
            if (!wrap_edges) return 0;
            nr = (nr + GRID_SIDE) % GRID_SIDE;
            nc = (nc + GRID_SIDE) % GRID_SIDE;
        end
        return (prior_grid[nr * GRID_SIDE + nc] > 3) ? 1 : 0;
    endfunction

    function automatic sweep_result_t apply_command(logic [1:0] mode, logic [5:0] row,
                                                    logic [5:0] col, logic [15:0] value);
        sweep_result_t res;
        int h;
        int topples;
        int k;
        res = '0;
        topples = 0;
        case (mode)
            MODE_FILL: begin
                for (int i = 0; i < CELLS; i++) height_grid[i] = fill_value;
            end
            MODE_WRITE: begin
                if (row < GRID_SIDE && col < GRID_SIDE)
                    height_grid[row * GRID_SIDE + col] = value;
            end
            MODE_READ: begin
                if (row < GRID_SIDE && col < GRID_SIDE)
                    res.cell_value = height_grid[row * GRID_SIDE + col];
            end
            default: begin
                prior_grid = height_grid;
                for (int r = 0; r < GRID_SIDE; r++) begin
                    for (int c = 0; c < GRID_SIDE; c++) begin
                        h = prior_grid[r * GRID_SIDE + c];
                        if (h > 3) begin
                            h -= 4;
                            topples++;
                        end
                        h += neighbour_grain(r, c, -1, 0) + neighbour_grain(r, c, 1, 0)
                           + neighbour_grain(r, c, 0, -1) + neighbour_grain(r, c, 0, 1);
                        if (h > 65535) begin
                            h = 65535;
                            res.clipped = 1'b1;
                        end
                        height_grid[r * GRID_SIDE + c] = h[15:0];
                    end
                end
                // The drop lands after the sweep and saturates like any other cell.
                if (drop_row < GRID_SIDE && drop_col < GRID_SIDE) begin
                    k = drop_row * GRID_SIDE + drop_col;
                    h = height_grid[k] + drop_amount;
                    if (h > 65535) begin
                        h = 65535;
                        res.clipped = 1'b1;
                    end
                    height_grid[k] = h[15:0];
                end
                if (topples > 8191) topples = 8191;
                res.topple_count = topples[CNT_W-1:0];
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        sweep_result_t seen;
        sweep_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) height_grid[i] = '0;
            fill_value  = 16'd7;
            drop_row    = 6'd32;
            drop_col    = 6'd32;
            drop_amount = 8'd3;
            wrap_edges  = 1'b0;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL: fill_value  = i_cfg_data;
                    CFG_DROW: drop_row    = i_cfg_data[5:0];
                    CFG_DCOL: drop_col    = i_cfg_data[5:0];
                    CFG_DAMT: drop_amount = i_cfg_data[7:0];
                    CFG_WRAP: wrap_edges  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                seen = '{out_ch.cell_value, out_ch.topple_count, out_ch.clipped};
                if (expected_words.size() == 0) begin
                    $error("result word with no command outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (seen.cell_value !== want.cell_value)
                        $error("cell_value expected %0d got %0d", want.cell_value,
                               seen.cell_value);
                    if (seen.topple_count !== want.topple_count)
                        $error("topple_count expected %0d got %0d", want.topple_count,
                               seen.topple_count);
                    if (seen.clipped !== want.clipped)
                        $error("clipped expected %0d got %0d", want.clipped, seen.clipped);
                    if (seen !== want) o_fail_count <= o_fail_count + 1;
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(apply_command(in_ch.mode, in_ch.row, in_ch.col,
                                                       in_ch.value));
        end
        o_pending <= expected_words.size();
    end
endmodule

### dv/sandpile_toppling_step_unit_tb.sv
`timescale 1ns / 1ps
module sandpile_toppling_step_unit_tb;
    import sps_pkg::*;

    // Register index past the last one; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
    // The limit leaves a wide margin for the whole run, sweeps included.
    localparam int CYCLE_LIMIT = 4_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;

    sps_in_if  in_ch ();
    sps_out_if out_ch ();

    sandpile_toppling_step_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    sandpile_sweep_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one command word. The valid is only lowered when an idle gap is taken, so a
    // word that follows right away keeps valid high and just replaces the payload.
    task automatic send_command(logic [1:0] mode, logic [5:0] row, logic [5:0] col,
                                logic [15:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Holds the input channel quiet until every outstanding result word has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register writes only happen once the block has nothing in flight.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_command();
        int pick;
        logic [15:0] value;
        pick = $urandom_range(99);
        // Mostly small heights so that toppling chains form; now and then the full range.
        value = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(9));
        if (pick < 35)
            send_command(MODE_WRITE, 6'($urandom), 6'($urandom), value);
        else if (pick < 65)
            send_command(MODE_READ, 6'($urandom), 6'($urandom), 16'($urandom));
        else if (pick < 92)
            send_command(MODE_SWEEP, 6'($urandom), 6'($urandom), 16'($urandom));
        else
            send_command(MODE_FILL, 6'($urandom), 6'($urandom), 16'($urandom));
    endtask

    initial begin
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_FILL;
        in_ch.row      = '0;
        in_ch.col      = '0;
        in_ch.value    = '0;
        out_ch.ready   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: corners, full-scale heights, both boundaries and saturation.
        send_command(MODE_READ, 6'd0, 6'd0, 16'hFFFF);
        send_command(MODE_WRITE, 6'd0, 6'd0, 16'hFFFF);
        send_command(MODE_WRITE, 6'd63, 6'd63, 16'd4);
        send_command(MODE_WRITE, 6'd0, 6'd63, 16'd5);
        send_command(MODE_READ, 6'd0, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd63, 6'd63, 16'd0);
        send_command(MODE_SWEEP, 6'd0, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd1, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd32, 6'd32, 16'd0);
        write_register(CFG_WRAP, 16'd1);
        write_register(CFG_DROW, 16'd0);
        write_register(CFG_DCOL, 16'd63);
        send_command(MODE_SWEEP, 6'd0, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd63, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd0, 6'd63, 16'd0);
        write_register(CFG_FILL, 16'hFFFF);
        write_register(CFG_DAMT, 16'd255);
        send_command(MODE_FILL, 6'd0, 6'd0, 16'd0);
        // Every cell stays at full height, so the drop has to saturate.
        send_command(MODE_SWEEP, 6'd0, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd0, 6'd63, 16'd0);
        write_register(CFG_SPARE, 16'hFFFF);
        write_register(CFG_FILL, 16'd0);
        write_register(CFG_DAMT, 16'd0);
        write_register(CFG_DROW, 16'd63);
        write_register(CFG_DCOL, 16'd0);
        write_register(CFG_WRAP, 16'd0);
        send_command(MODE_FILL, 6'd0, 6'd0, 16'd0);
        send_command(MODE_WRITE, 6'd63, 6'd0, 16'd4);
        send_command(MODE_SWEEP, 6'd0, 6'd0, 16'd0);
        send_command(MODE_READ, 6'd62, 6'd0, 16'd0);

        // Random part: four phases of sender idles and receiver stalls, new settings each.
        for (int phase = 0; phase < 4; phase++) begin
            write_register(CFG_FILL, ($urandom_range(3) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(7)));
            write_register(CFG_DROW, 16'($urandom_range(63)));
            write_register(CFG_DCOL, 16'($urandom_range(63)));
            write_register(CFG_DAMT, 16'($urandom_range(255)));
            write_register(CFG_WRAP, 16'($urandom_range(1)));
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            send_command(MODE_FILL, 6'd0, 6'd0, 16'd0);
            for (int n = 0; n < 27; n++) begin
                random_command();
                // Once per phase the sender waits for the block to empty completely.
                if (n == 17) drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### files.f
design/sps_pkg.sv
design/sps_in_if.sv
design/sps_out_if.sv
design/sps_ctrl.sv
design/sps_dp.sv
design/sandpile_toppling_step_unit.sv
dv/sandpile_sweep_checker.sv
dv/sandpile_toppling_step_unit_tb.sv
